// ----- rtl/table_nco_sincos_top_defines.svh -----
// Assertion macros for the checker file.
`ifndef TABLE_NCO_SINCOS_TOP_DEFINES_SVH
`define TABLE_NCO_SINCOS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define TNCO_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define TNCO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/tnco_pkg.sv -----
package tnco_pkg;

   localparam int unsigned PHASE_WIDTH        = 32;
   localparam int unsigned SAMPLE_WIDTH       = 16;
   localparam int unsigned TABLE_SIZE_DEFAULT = 1024;

   // Request queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int unsigned COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic MODE_GENERATE = 1'b0;
   localparam logic MODE_LOOKUP   = 1'b1;

   localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C235;
   localparam logic [63:0] ONE_Q62   = 64'h4000000000000000;
   localparam logic [63:0] AMPLITUDE = 64'd32767;
   localparam int unsigned SERIES_STEPS = 30;

   typedef struct packed {
      logic                   valid;
      logic [PHASE_WIDTH-1:0] phase;
   } tnco_push_type;

   typedef struct packed {
      logic                   valid;
      logic [PHASE_WIDTH-1:0] phase;
   } tnco_pop_type;

   // (a * b) >> 62 for Q2.62 operands, truncated to 64 bits
   function automatic logic [63:0] mul_q62_f(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return prod[125:62];
   endfunction

   // Unsigned 64-bit quotient by shift and subtract
   function automatic logic [63:0] div_u64_f(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Taylor series of sin (odd) or cos, x at most pi/4, Q2.62
   function automatic logic [63:0] series_q62_f(input logic [63:0] x, input logic odd);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] n;
      logic [63:0] div_val;
      logic        minus;
      x2    = mul_q62_f(x, x);
      term  = odd ? x : ONE_Q62;
      sum   = term;
      n     = odd ? 64'd1 : 64'd0;
      minus = 1'b1;
      for (int s = 0; s < SERIES_STEPS; s++) begin
         if (term != 64'd0 && n < 64'd60) begin
            div_val = (n + 64'd1) * (n + 64'd2);
            term    = div_u64_f(mul_q62_f(term, x2), div_val);
            sum     = minus ? sum - term : sum + term;
            minus   = !minus;
            n       = n + 64'd2;
         end
      end
      return sum;
   endfunction

   // round(32767 * s / 2^62), halves away from zero
   function automatic logic [SAMPLE_WIDTH-1:0] scale_round_f(input logic [63:0] s);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      a = AMPLITUDE * (s >> 31);
      b = AMPLITUDE * (s & 64'h7FFFFFFF);
      c = a + (b >> 31);
      return SAMPLE_WIDTH'((c + 64'h40000000) >> 31);
   endfunction

   // Sine magnitude at quarter-turn index i (0 to n/4)
   function automatic logic [SAMPLE_WIDTH-1:0] quarter_value_f(input int unsigned i,
                                                               input int unsigned n,
                                                               input int unsigned k);
      int unsigned j;
      logic [63:0] frac;
      logic [63:0] x;
      j    = (i <= (n >> 3)) ? i : (n >> 2) - i;
      frac = (64'(j) * 64'd2) << (62 - k);
      x    = mul_q62_f(PI_Q62, frac);
      return scale_round_f(series_q62_f(x, i <= (n >> 3)));
   endfunction

   // Table entry j of a 2^k entry sine table
   function automatic logic signed [SAMPLE_WIDTH-1:0] sine_entry_f(input int unsigned j,
                                                                  input int unsigned k);
      int unsigned n;
      int unsigned q;
      logic [SAMPLE_WIDTH-1:0] v;
      n = 1 << k;
      q = n >> 2;
      if (j <= q) begin
         v = quarter_value_f(j, n, k);
      end else if (j <= 2 * q) begin
         v = quarter_value_f(2 * q - j, n, k);
      end else if (j <= 3 * q) begin
         v = -quarter_value_f(j - 2 * q, n, k);
      end else begin
         v = -quarter_value_f(n - j, n, k);
      end
      return signed'(v);
   endfunction

endpackage

// ----- rtl/table_nco_sincos_top.sv -----
// Path: a queue slot, then a registered dual-port table read, to the response valid.
// Throughput: one request per cycle unless the response side stalls (rsp_ready low).
// A 2-entry queue between front and back lets each side stall on its own.
// Reset (synchronous, active high) clears the accumulator, the phase step, the queue
// and the response valid; the sine table is constant and needs no fill after reset.
module table_nco_sincos_top import tnco_pkg::*; #(
   parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic                           req_restart,
   input  logic [PHASE_WIDTH-1:0]         req_phase,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sine,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_cosine,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [PHASE_WIDTH-1:0]         csr_phase_step
);

   tnco_push_type push;
   tnco_pop_type  pop;
   logic          queue_full;
   logic          pop_ready;

   tnco_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_restart    (req_restart),
      .req_phase      (req_phase),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_phase_step (csr_phase_step),
      .queue_full     (queue_full),
      .push           (push)
   );

   tnco_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop       (pop),
      .pop_ready (pop_ready)
   );

   tnco_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .pop_ready  (pop_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sine   (rsp_sine),
      .rsp_cosine (rsp_cosine)
   );

endmodule

// ----- rtl/tnco_front.sv -----
module tnco_front import tnco_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic                   req_restart,
   input  logic [PHASE_WIDTH-1:0] req_phase,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [PHASE_WIDTH-1:0] csr_phase_step,
   input  logic                   queue_full,
   output tnco_push_type          push
);

   logic [PHASE_WIDTH-1:0] acc_ff, acc_in;
   logic [PHASE_WIDTH-1:0] step_ff, step_in;
   logic [PHASE_WIDTH-1:0] gen_phase;
   logic                   accept;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;

   always_comb begin
      accept     = req_valid && !queue_full;
      gen_phase  = req_restart ? '0 : acc_ff;
      push.valid = accept;
      push.phase = (req_mode == MODE_LOOKUP) ? req_phase : gen_phase;
      acc_in     = acc_ff;
      if (accept && req_mode == MODE_GENERATE) begin
         acc_in = gen_phase + step_ff;
      end
      step_in = csr_valid ? csr_phase_step : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         step_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         step_ff <= step_in;
      end
   end

endmodule

// ----- rtl/tnco_queue.sv -----
module tnco_queue import tnco_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  tnco_push_type push,
   output logic          full,
   output tnco_pop_type  pop,
   input  logic          pop_ready
);

   logic [PHASE_WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   do_pop;

   function automatic logic [PTR_BITS-1:0] next_ptr_f(input logic [PTR_BITS-1:0] ptr);
      return (ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      full      = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
      pop.valid = (count_ff != '0);
      pop.phase = mem_ff[rd_ptr_ff];
      do_pop    = pop.valid && pop_ready;
      wr_ptr_in = push.valid ? next_ptr_f(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr_f(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.phase;
      end
   end

endmodule

// ----- rtl/tnco_back.sv -----
module tnco_back import tnco_pkg::*; #(
   parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tnco_pop_type                   pop,
   output logic                           pop_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sine,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_cosine
);

   // Largest power of two not above TABLE_SIZE
   localparam int unsigned INDEX_BITS = $clog2(TABLE_SIZE + 1) - 1;
   localparam int unsigned ROM_SIZE   = 1 << INDEX_BITS;
   localparam int unsigned QUARTER    = ROM_SIZE / 4;

   logic signed [SAMPLE_WIDTH-1:0] rom_w [ROM_SIZE];
   logic signed [SAMPLE_WIDTH-1:0] sine_ff, cosine_ff;
   logic                           valid_ff, valid_in;
   logic [INDEX_BITS-1:0]          sin_idx, cos_idx;
   logic                           take;

   for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
      localparam logic signed [SAMPLE_WIDTH-1:0] ROM_VALUE = sine_entry_f(g, INDEX_BITS);
      assign rom_w[g] = ROM_VALUE;
   end

   always_comb begin
      pop_ready = !valid_ff || rsp_ready;
      take      = pop.valid && pop_ready;
      sin_idx   = pop.phase[PHASE_WIDTH-1 -: INDEX_BITS];
      // cosine leads sine by a quarter turn
      cos_idx   = sin_idx + INDEX_BITS'(QUARTER);
      valid_in  = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sine_ff   <= rom_w[sin_idx];
         cosine_ff <= rom_w[cos_idx];
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sine   = sine_ff;
   assign rsp_cosine = cosine_ff;

endmodule

// ----- rtl/tnco_port_checker.sv -----
`include "table_nco_sincos_top_defines.svh"

module tnco_port_checker import tnco_pkg::*; (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_sine,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_cosine
);

   logic [3:0] pending_ff, pending_in;

   // Track requests taken but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pending_in = pending_ff + 1'b1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `TNCO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sine) && $stable(rsp_cosine), "response changed while stalled")
   `TNCO_ASSERT_NOW(a_rsp_has_req, rsp_valid, pending_ff != 4'd0, "response without a pending request")
   `TNCO_ASSERT_NOW(a_pending_cap, 1'b1, pending_ff <= 4'd3, "more requests in flight than storage")
   `TNCO_ASSERT_NOW(a_ready_when_empty, pending_ff == 4'd0, req_ready, "request stalled with nothing in flight")
   `TNCO_ASSERT_NOW(a_amp_range, rsp_valid, rsp_sine != -16'sd32768 && rsp_cosine != -16'sd32768, "sample outside amplitude range")

endmodule

bind table_nco_sincos_top tnco_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sine   (rsp_sine),
   .rsp_cosine (rsp_cosine)
);

// ----- bench/table_nco_sincos_top_tb.sv -----
module table_nco_sincos_top_tb;
   import tnco_pkg::*;

   localparam int unsigned CLOCK_PERIOD = 8;
   localparam int unsigned LUT_SIZE     = 1024;
   localparam int unsigned LUT_BITS     = $clog2(LUT_SIZE);
   localparam int unsigned QUARTER      = LUT_SIZE / 4;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned BURST_ITEMS  = 240;

   // pi and one in unsigned Q2.62
   localparam logic [63:0] PI_FX  = 64'hC90F_DAA2_2168_C235;
   localparam logic [63:0] ONE_FX = 64'h4000_0000_0000_0000;

   localparam logic signed [SAMPLE_WIDTH-1:0] ZERO     = 16'sd0;
   localparam logic signed [SAMPLE_WIDTH-1:0] FULL     = 16'sd32767;
   localparam logic signed [SAMPLE_WIDTH-1:0] NEG_FULL = -16'sd32767;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sine;
      logic signed [SAMPLE_WIDTH-1:0] cosine;
   } sincos_t;

   typedef struct packed {
      logic                           mode;
      logic                           restart;
      logic [PHASE_WIDTH-1:0]         phase;
      logic                           load_step;
      logic [PHASE_WIDTH-1:0]         step;
      logic                           known;
      logic signed [SAMPLE_WIDTH-1:0] sine;
      logic signed [SAMPLE_WIDTH-1:0] cosine;
   } directed_row_t;

   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_ready;
   logic                           req_mode       = MODE_GENERATE;
   logic                           req_restart    = 1'b0;
   logic [PHASE_WIDTH-1:0]         req_phase      = '0;
   logic                           rsp_valid;
   logic                           rsp_ready      = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sine;
   logic signed [SAMPLE_WIDTH-1:0] rsp_cosine;
   logic                           csr_valid      = 1'b0;
   logic                           csr_ready;
   logic [PHASE_WIDTH-1:0]         csr_phase_step = '0;

   logic signed [SAMPLE_WIDTH-1:0] sine_lut [0:LUT_SIZE-1];
   logic [PHASE_WIDTH-1:0]         nco_acc  = '0;
   logic [PHASE_WIDTH-1:0]         nco_step = '0;
   sincos_t                        pending_pairs [$];
   logic                           idle_on = 1'b1;
   int                             stall_left = 0;
   int                             error_count = 0;
   int unsigned                    cycle_count = 0;

   directed_row_t directed_plan [0:23] = '{
      '{MODE_GENERATE, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_GENERATE, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_LOOKUP,   1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_LOOKUP,   1'b0, 32'h4000_0000, 1'b0, 32'h0, 1'b1, FULL, ZERO},
      '{MODE_LOOKUP,   1'b0, 32'h8000_0000, 1'b0, 32'h0, 1'b1, ZERO, NEG_FULL},
      '{MODE_LOOKUP,   1'b0, 32'hC000_0000, 1'b0, 32'h0, 1'b1, NEG_FULL, ZERO},
      // restart has no effect on a lookup
      '{MODE_LOOKUP,   1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0, ZERO, ZERO},
      // index is the floor of the phase
      '{MODE_LOOKUP,   1'b0, 32'h003F_FFFF, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_LOOKUP,   1'b0, 32'h0040_0000, 1'b0, 32'h0, 1'b0, ZERO, ZERO},
      '{MODE_LOOKUP,   1'b0, 32'h1FFF_FFFF, 1'b0, 32'h0, 1'b0, ZERO, ZERO},
      '{MODE_LOOKUP,   1'b0, 32'h2000_0000, 1'b0, 32'h0, 1'b0, ZERO, ZERO},
      '{MODE_LOOKUP,   1'b0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0, ZERO, ZERO},
      '{MODE_LOOKUP,   1'b0, 32'hBFFF_FFFF, 1'b0, 32'h0, 1'b0, ZERO, ZERO},
      '{MODE_LOOKUP,   1'b0, 32'h5555_5555, 1'b0, 32'h0, 1'b0, ZERO, ZERO},
      // phase field is ignored when generating
      '{MODE_GENERATE, 1'b0, 32'h1234_5678, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_GENERATE, 1'b1, 32'h0000_0000, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      // quarter-turn step walks the four axis points
      '{MODE_GENERATE, 1'b0, 32'h0000_0000, 1'b1, 32'h4000_0000, 1'b1, ZERO, FULL},
      '{MODE_GENERATE, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, FULL, ZERO},
      '{MODE_GENERATE, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, ZERO, NEG_FULL},
      '{MODE_LOOKUP,   1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_GENERATE, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, NEG_FULL, ZERO},
      '{MODE_GENERATE, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_GENERATE, 1'b1, 32'h0000_0000, 1'b0, 32'h0, 1'b1, ZERO, FULL},
      '{MODE_GENERATE, 1'b0, 32'h0000_0000, 1'b0, 32'h0, 1'b1, FULL, ZERO}
   };

   table_nco_sincos_top #(
      .TABLE_SIZE (LUT_SIZE)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_restart    (req_restart),
      .req_phase      (req_phase),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sine       (rsp_sine),
      .rsp_cosine     (rsp_cosine),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_phase_step (csr_phase_step)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Fixed-point product of two Q2.62 values
   function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // Alternating power series: sine when odd_fn is set, else cosine
   function automatic logic [63:0] taylor(input logic [63:0] x, input bit odd_fn);
      logic [63:0] x_sq;
      logic [63:0] term;
      logic [63:0] total;
      int unsigned k;
      bit          negate;
      x_sq   = fx_mul(x, x);
      term   = odd_fn ? x : ONE_FX;
      total  = term;
      k      = odd_fn ? 1 : 0;
      negate = 1'b1;
      while (term != 64'd0 && k < 60) begin
         term   = fx_mul(term, x_sq) / 64'((k + 1) * (k + 2));
         total  = negate ? total - term : total + term;
         negate = !negate;
         k      = k + 2;
      end
      return total;
   endfunction

   // Scale a Q2.62 magnitude to Q1.15 full scale, halves away from zero
   function automatic logic [SAMPLE_WIDTH-1:0] q15_round(input logic [63:0] s);
      logic [127:0] scaled;
      scaled = ((({64'd0, s} * 128'd32767) >> 31) + 128'd1073741824) >> 31;
      return scaled[SAMPLE_WIDTH-1:0];
   endfunction

   // Sine magnitude at index i of the first quadrant; upper half uses cosine
   function automatic logic [SAMPLE_WIDTH-1:0] quadrant_mag(input int unsigned i);
      bit          near_zero;
      int unsigned offset;
      logic [63:0] angle;
      near_zero = (i <= LUT_SIZE / 8);
      offset    = near_zero ? i : QUARTER - i;
      angle     = fx_mul(PI_FX, (64'(offset) * 64'd2) << (62 - LUT_BITS));
      return q15_round(taylor(angle, near_zero));
   endfunction

   function automatic sincos_t next_sincos(input logic mode, input logic restart,
                                           input logic [PHASE_WIDTH-1:0] phase);
      logic [PHASE_WIDTH-1:0] angle;
      logic [LUT_BITS-1:0]    s_idx;
      logic [LUT_BITS-1:0]    c_idx;
      sincos_t                pair;
      if (mode == MODE_LOOKUP) begin
         angle = phase;
      end else begin
         if (restart)
            nco_acc = '0;
         angle   = nco_acc;
         nco_acc = nco_acc + nco_step;
      end
      s_idx       = angle[PHASE_WIDTH-1 -: LUT_BITS];
      c_idx       = s_idx + LUT_BITS'(QUARTER);
      pair.sine   = sine_lut[s_idx];
      pair.cosine = sine_lut[c_idx];
      return pair;
   endfunction

   task automatic send_req(input logic mode, input logic restart,
                           input logic [PHASE_WIDTH-1:0] phase,
                           input logic known, input sincos_t typed);
      sincos_t pred;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_restart <= restart;
      req_phase   <= phase;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = next_sincos(mode, restart, phase);
      pending_pairs.push_back(known ? typed : pred);
   endtask

   // Hold off new requests until every response is back
   task automatic wait_settled();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_step(input logic [PHASE_WIDTH-1:0] value);
      csr_valid      <= 1'b1;
      csr_phase_step <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      nco_step  = value;
   endtask

   task automatic random_burst(input int count, input bit allow_idle);
      logic                   mode;
      logic                   restart;
      logic [PHASE_WIDTH-1:0] phase;
      int                     pick;
      for (int i = 0; i < count; i++) begin
         if (i % 48 == 0)
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
         pick    = $urandom_range(0, 15);
         mode    = (pick >= 11) ? MODE_LOOKUP : MODE_GENERATE;
         restart = ($urandom_range(0, 15) == 0);
         phase   = $urandom;
         if (pick == 15) begin
            case ($urandom_range(0, 5))
               0: phase = 32'h0000_0000;
               1: phase = 32'hFFFF_FFFF;
               2: phase = {2'($urandom_range(0, 3)), 30'h0};
               3: phase = phase & 32'hFFC0_0000;
               4: phase = phase | 32'h003F_FFFF;
               default: ;
            endcase
         end
         send_req(mode, restart, phase, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_pairs.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side back-pressure in short bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      sincos_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            $display("%0t: unexpected response, actual sine %0d cosine %0d",
                     $time, rsp_sine, rsp_cosine);
            error_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_sine !== want.sine) begin
               $display("%0t: sine mismatch, expected %0d, actual %0d",
                        $time, want.sine, rsp_sine);
               error_count++;
            end
            if (rsp_cosine !== want.cosine) begin
               $display("%0t: cosine mismatch, expected %0d, actual %0d",
                        $time, want.cosine, rsp_cosine);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [PHASE_WIDTH-1:0] step_plan [0:5];
      sincos_t                typed;

      for (int j = 0; j < LUT_SIZE; j++) begin
         if (j <= QUARTER)
            sine_lut[j] = quadrant_mag(j);
         else if (j <= 2 * QUARTER)
            sine_lut[j] = quadrant_mag(2 * QUARTER - j);
         else if (j <= 3 * QUARTER)
            sine_lut[j] = -quadrant_mag(j - 2 * QUARTER);
         else
            sine_lut[j] = -quadrant_mag(LUT_SIZE - j);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[r]) begin
         if (directed_plan[r].load_step) begin
            wait_settled();
            write_step(directed_plan[r].step);
         end
         typed.sine   = directed_plan[r].sine;
         typed.cosine = directed_plan[r].cosine;
         send_req(directed_plan[r].mode, directed_plan[r].restart,
                  directed_plan[r].phase, directed_plan[r].known, typed);
      end
      wait_settled();

      step_plan[0] = 32'hFFFF_FFFF;
      step_plan[1] = 32'h0000_0001;
      step_plan[2] = 32'h8000_0000;
      step_plan[3] = 32'h0000_0000;
      step_plan[4] = $urandom;
      step_plan[5] = $urandom_range(1, 32'h0100_0000);
      foreach (step_plan[p]) begin
         write_step(step_plan[p]);
         // final burst runs at full rate on both sides
         random_burst(BURST_ITEMS, p != 5);
         wait_settled();
      end

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/tnco_pkg.sv
rtl/tnco_front.sv
rtl/tnco_queue.sv
rtl/tnco_back.sv
rtl/table_nco_sincos_top.sv
rtl/tnco_port_checker.sv
bench/table_nco_sincos_top_tb.sv
